// File: hdl/btda_pkg.sv
package btda_pkg;

    localparam int VALUE_W = 32;
    localparam int STEP_W  = 5;
    localparam int CHAR_W  = 7;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_POINT = 7'd46;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_DIGIT,
        ST_POINT
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
        logic next_digit;
        logic emit_digit;
        logic emit_point;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic top_zero;
        logic kind;
    } t_status;

endpackage

// File: hdl/btda_datapath.sv
module btda_datapath
    import btda_pkg::*;
#(
    parameter int DIGIT_COUNT = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_kind,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [CHAR_W-1:0]  o_char,
    output logic               o_last
);

    localparam int BCD_W = 4 * DIGIT_COUNT;

    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic               r_kind;
    logic [BCD_W-1:0]   n_adj;
    logic [3:0]         w_top;
    logic               r_ovalid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;

    // add-3 correction on every digit before the shift
    always_comb begin
        for (int d = 0; d < DIGIT_COUNT; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                n_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                n_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    assign w_top = r_bcd[BCD_W-1 -: 4];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin  <= i_value;
            r_bcd  <= '0;
            r_kind <= i_kind;
        end else if (i_cmd.shift) begin
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
            r_bcd <= {n_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
        end else if (i_cmd.next_digit) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_digit || i_cmd.emit_point) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_digit) begin
            r_char <= ASCII_ZERO + {3'd0, w_top};
            r_last <= i_cmd.last;
        end else if (i_cmd.emit_point) begin
            r_char <= ASCII_POINT;
            r_last <= 1'b0;
        end
    end

    assign o_status.out_free = !r_ovalid || i_m_tready;
    assign o_status.top_zero = (w_top == 4'd0);
    assign o_status.kind     = r_kind;

    assign o_m_tvalid = r_ovalid;
    assign o_char     = r_char;
    assign o_last     = r_last;

endmodule

// File: hdl/btda_ctrl.sv
module btda_ctrl
    import btda_pkg::*;
#(
    parameter int DIGIT_COUNT = 10
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int IDX_W = $clog2(DIGIT_COUNT);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIGIT_COUNT - 1);
    localparam logic [IDX_W-1:0] IDX_UNIT = IDX_W'(DIGIT_COUNT - 3);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_seen, n_seen;
    logic [IDX_W-1:0]  w_lead_end;

    assign w_lead_end = i_status.kind ? IDX_UNIT : IDX_LAST;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_idx   <= '0;
            r_seen  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_idx   <= n_idx;
            r_seen  <= n_seen;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_idx      = r_idx;
        n_seen     = r_seen;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_idx      = '0;
                    n_seen     = 1'b0;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.shift = 1'b1;
                n_step      = r_step + 1'b1;
                if (r_step == {STEP_W{1'b1}}) begin
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (r_idx < w_lead_end && !r_seen && i_status.top_zero) begin
                    // leading zero: drop it
                    o_cmd.next_digit = 1'b1;
                    n_idx            = r_idx + 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    o_cmd.next_digit = 1'b1;
                    o_cmd.last       = (r_idx == IDX_LAST);
                    n_seen           = 1'b1;
                    if (r_idx == IDX_LAST) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        if (i_status.kind && r_idx == IDX_UNIT) begin
                            n_state = ST_POINT;
                        end
                    end
                end
            end
            ST_POINT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_point = 1'b1;
                    n_state          = ST_DIGIT;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_last_on_final_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.last |-> (o_cmd.emit_digit && r_idx == IDX_LAST))
        else $error("last flag off the final digit");

    a_point_only_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POINT) |-> i_status.kind)
        else $error("decimal point in integer mode");

    a_load_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_CONV && r_step == '0))
        else $error("conversion did not start after load");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_digit || o_cmd.emit_point) |-> i_status.out_free)
        else $error("output overwritten");

endmodule

// File: hdl/binary_to_decimal_ascii_core.sv
// Flow: accept a value, run the double-dabble shift steps, then walk every digit
// position (suppressed zeros included), plus the point in hundredths mode.
// A new value is accepted only after the final digit of the previous one is issued.
// The 32-step shift-add-3 conversion sets the rate; output stalls slow it further.
// Reset (i_rst_n low, synchronous) returns the controller to idle and drops o_m_tvalid.
module binary_to_decimal_ascii_core
    import btda_pkg::*;
#(
    parameter int DIGIT_COUNT = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // [31:0] value
    input  logic [0:0]  i_s_tuser,  // [0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // [6:0] character, [7] zero
    output logic        o_m_tlast
);

    t_cmd              w_cmd;
    t_status           w_status;
    logic [CHAR_W-1:0] w_char;

    btda_ctrl #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    btda_datapath #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value    (i_s_tdata),
        .i_kind     (i_s_tuser[0]),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_char     (w_char),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, w_char};

endmodule

// File: dv/tb_binary_to_decimal_ascii_core.sv
`timescale 1ns / 100ps

module tb_binary_to_decimal_ascii_core;
    import btda_pkg::*;

    localparam int DIGITS       = 10;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 400;
    localparam int GAP_MAX      = 19;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int DIRECTED     = 19;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_char_t;

    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] value;
    } request_t;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;  // [31:0] value
    logic [0:0]  i_s_tuser  = '0;  // [0] kind
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;        // [6:0] character, [7] zero
    logic        o_m_tlast;

    text_char_t text_q[$];
    int         errors         = 0;
    int         idle_cycles    = 0;
    bit         stimulus_done  = 1'b0;
    bit         burst_tx       = 1'b0;

    // directed requests; an empty text means the predictor supplies the result
    request_t dir_req [DIRECTED] = '{
        '{1'b0, 32'd0},          '{1'b1, 32'd0},
        '{1'b0, 32'hFFFF_FFFF},  '{1'b1, 32'hFFFF_FFFF},
        '{1'b0, 32'd1},          '{1'b1, 32'd1},
        '{1'b1, 32'd99},         '{1'b1, 32'd100},
        '{1'b0, 32'd9},          '{1'b0, 32'd10},
        '{1'b0, 32'd999999999},  '{1'b0, 32'd1000000000},
        '{1'b1, 32'd1000000000}, '{1'b1, 32'd1005},
        '{1'b0, 32'd1234567890}, '{1'b0, 32'h8000_0000},
        '{1'b1, 32'h5555_5555},  '{1'b0, 32'hAAAA_AAAA},
        '{1'b1, 32'd12345}
    };
    string dir_text [DIRECTED] = '{
        "0", "0.00", "4294967295", "42949672.95", "1", "0.01", "0.99", "1.00",
        "9", "10", "999999999", "1000000000", "10000000.00", "10.05",
        "", "", "", "", ""
    };

    binary_to_decimal_ascii_core #(
        .DIGIT_COUNT(DIGITS)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic void push_char(input logic [CHAR_W-1:0] ch);
        text_char_t c;
        c.character = ch;
        c.last      = 1'b0;
        text_q.push_back(c);
    endfunction

    function automatic void mark_last();
        text_char_t c;
        c = text_q.pop_back();
        c.last = 1'b1;
        text_q.push_back(c);
    endfunction

    function automatic void push_text(input string s);
        byte b;
        for (int i = 0; i < s.len(); i++) begin
            b = s[i];
            push_char(b[CHAR_W-1:0]);
        end
        mark_last();
    endfunction

    function automatic void push_decimal_text(input logic kind, input logic [31:0] value);
        logic [3:0]      dig [DIGITS];
        longint unsigned rest;
        int              lead;
        bit              seen;
        rest = {32'd0, value};
        seen = 1'b0;
        for (int i = DIGITS - 1; i >= 0; i--) begin
            dig[i] = 4'(rest % 10);
            rest   = rest / 10;
        end
        lead = kind ? DIGITS - 3 : DIGITS - 1;
        for (int i = 0; i < lead; i++) begin
            if (dig[i] != 0 || seen) begin
                seen = 1'b1;
                push_char(ASCII_ZERO + {3'd0, dig[i]});
            end
        end
        push_char(ASCII_ZERO + {3'd0, dig[lead]});
        if (kind) begin
            push_char(ASCII_POINT);
            push_char(ASCII_ZERO + {3'd0, dig[DIGITS-2]});
            push_char(ASCII_ZERO + {3'd0, dig[DIGITS-1]});
        end
        mark_last();
    endfunction

    function automatic logic [31:0] random_value();
        logic [31:0] p;
        int          k;
        case ($urandom_range(0, 4))
            0: random_value = $urandom;
            1: random_value = $urandom >> $urandom_range(0, 31);
            2: random_value = $urandom_range(0, 999);
            3: begin
                k = $urandom_range(0, 9);
                p = 1;
                repeat (k) p = p * 10;
                random_value = p + $urandom_range(0, 2) - 1;
            end
            default: random_value = 32'hFFFF_FFFF - $urandom_range(0, 300);
        endcase
    endfunction

    task automatic send_request(input request_t req, input string text);
        int gap;
        gap = burst_tx ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req.kind;
        i_s_tdata  <= req.value;
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
        if (text.len() > 0) begin
            push_text(text);
        end else begin
            push_decimal_text(req.kind, req.value);
        end
        if ($urandom_range(0, 29) == 0) burst_tx = !burst_tx;
    endtask

    task automatic hold_until_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (text_q.size() != 0);
    endtask

    initial begin
        request_t req;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int n = 0; n < DIRECTED; n++) begin
            send_request(dir_req[n], dir_text[n]);
        end
        hold_until_drained();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            req.kind  = 1'($urandom_range(0, 1));
            req.value = random_value();
            send_request(req, "");
            if (n == RANDOM_ITEMS / 2) hold_until_drained();
        end
        i_s_tvalid <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial begin
        int  stall;
        bit  burst;
        burst = 1'b0;
        @(posedge i_clk);
        forever begin
            stall = burst ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && o_m_tvalid && i_m_tready));
            if ($urandom_range(0, 29) == 0) burst = !burst;
        end
    end

    always @(posedge i_clk) begin
        text_char_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (text_q.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h last %b",
                                          o_m_tdata, o_m_tlast));
            end else begin
                want = text_q.pop_front();
                if (o_m_tdata[CHAR_W-1:0] !== want.character)
                    report_mismatch($sformatf("character 0x%02h, want 0x%02h",
                                              o_m_tdata[CHAR_W-1:0], want.character));
                if (o_m_tlast !== want.last)
                    report_mismatch($sformatf("tlast %b, want %b", o_m_tlast, want.last));
                if (o_m_tdata[7] !== 1'b0)
                    report_mismatch("tdata pad bit not zero");
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (stimulus_done);
        do @(posedge i_clk); while (text_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
